/* rtl/mvm_pkg.sv */
// Shared types and constants of the matrix-vector multiplier.
`timescale 1ns / 1ps

package mvm_pkg;

   localparam logic [1:0] CMD_WRITE_MATRIX = 2'd0;
   localparam logic [1:0] CMD_WRITE_VECTOR = 2'd1;
   localparam logic [1:0] CMD_START        = 2'd2;

   localparam int OPERAND_W = 16;
   localparam int PRODUCT_W = 32;
   localparam int RESULT_W  = 36;
   localparam int INDEX_W   = 4;
   localparam int SIZE_W    = 5;

   localparam int RESULT_REACH = 16;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

   typedef struct packed {
      logic               valid;
      logic               first;
      logic               last_col;
      logic               last_row;
      logic [INDEX_W-1:0] row;
   } mac_ctl_type;

endpackage

/* rtl/mvm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mvm_mac.sv */
// Shared multiply-accumulate unit that builds one row result at a time.
`timescale 1ns / 1ps

module mvm_mac (
   input  logic                                        clock,
   input  logic                                        reset,
   input  mvm_pkg::mac_ctl_type                        ctl,
   input  logic signed [mvm_pkg::OPERAND_W-1:0]        matrix_data,
   input  logic signed [mvm_pkg::OPERAND_W-1:0]        vector_data,
   output logic                                        rsp_strobe,
   output logic [mvm_pkg::INDEX_W-1:0]                 rsp_index,
   output logic signed [mvm_pkg::RESULT_W-1:0]         rsp_value,
   output logic                                        rsp_last
);

   mvm_pkg::mac_ctl_type                        pctl_ff;
   logic signed [mvm_pkg::PRODUCT_W-1:0]        prod_ff;
   logic signed [mvm_pkg::PRODUCT_W-1:0]        prod_in;
   logic signed [mvm_pkg::RESULT_W-1:0]         acc_ff;
   logic signed [mvm_pkg::RESULT_W-1:0]         acc_in;
   logic                                        out_valid_ff;
   logic [mvm_pkg::INDEX_W-1:0]                 out_row_ff;
   logic                                        out_last_ff;

   assign prod_in = matrix_data * vector_data;

   always_comb begin
      acc_in = acc_ff;
      if (pctl_ff.valid) begin
         acc_in = (pctl_ff.first ? '0 : acc_ff) + mvm_pkg::RESULT_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pctl_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pctl_ff      <= ctl;
         out_valid_ff <= pctl_ff.valid && pctl_ff.last_col;
      end
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      out_row_ff  <= pctl_ff.row;
      out_last_ff <= pctl_ff.last_row;
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_index  = out_row_ff;
   assign rsp_value  = acc_ff;
   assign rsp_last   = out_last_ff;

endmodule

/* rtl/mvm_ctrl.sv */
// Sequencer that walks rows and columns of the active square through the MAC.
`timescale 1ns / 1ps

module mvm_ctrl #(
   parameter int MAX_DIM = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [1:0]                         command,
   input  logic [mvm_pkg::SIZE_W-1:0]         size,
   output logic                               busy,
   output logic [mvm_pkg::INDEX_W-1:0]        rd_row,
   output logic [mvm_pkg::INDEX_W-1:0]        rd_col,
   output mvm_pkg::mac_ctl_type               ctl
);

   localparam int CAP = (MAX_DIM < mvm_pkg::RESULT_REACH) ? MAX_DIM : mvm_pkg::RESULT_REACH;

   typedef enum logic {
      IDLE_ST,
      RUN_ST
   } state_type;

   state_type                       state_ff, state_in;
   logic [mvm_pkg::INDEX_W-1:0]     row_ff, row_in;
   logic [mvm_pkg::INDEX_W-1:0]     col_ff, col_in;
   logic [mvm_pkg::INDEX_W-1:0]     lim_ff, lim_in;
   mvm_pkg::mac_ctl_type            ctl_ff, ctl_in;
   logic [mvm_pkg::SIZE_W-1:0]      active;
   logic [mvm_pkg::INDEX_W-1:0]     lim_new;
   logic                            go;

   always_comb begin
      priority if (size == '0) begin
         active = mvm_pkg::SIZE_W'(1);
      end else if (int'(size) > CAP) begin
         active = mvm_pkg::SIZE_W'(CAP);
      end else begin
         active = size;
      end
   end

   assign lim_new = mvm_pkg::INDEX_W'(active - mvm_pkg::SIZE_W'(1));
   assign go      = start && (state_ff == IDLE_ST) && (command == mvm_pkg::CMD_START);

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      lim_in   = lim_ff;
      ctl_in   = '0;
      unique case (state_ff)
         IDLE_ST: begin
            if (go) begin
               state_in = RUN_ST;
               row_in   = '0;
               col_in   = '0;
               lim_in   = lim_new;
            end
         end
         RUN_ST: begin
            ctl_in.valid    = 1'b1;
            ctl_in.first    = (col_ff == '0);
            ctl_in.last_col = (col_ff == lim_ff);
            ctl_in.last_row = (row_ff == lim_ff);
            ctl_in.row      = row_ff;
            if (col_ff == lim_ff) begin
               col_in = '0;
               if (row_ff == lim_ff) begin
                  state_in = IDLE_ST;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE_ST;
         ctl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ctl_ff   <= ctl_in;
      end
      row_ff <= row_in;
      col_ff <= col_in;
      lim_ff <= lim_in;
   end

   assign busy   = (state_ff == RUN_ST);
   assign rd_row = row_ff;
   assign rd_col = col_ff;
   assign ctl    = ctl_ff;

   property p_counters_in_range;
      @(posedge clock) disable iff (reset)
         (state_ff == RUN_ST) |-> (row_ff <= lim_ff) && (col_ff <= lim_ff);
   endproperty
   a_counters_in_range: assert property (p_counters_in_range)
      else $error("row or column counter beyond the active size");

   property p_run_ends;
      @(posedge clock) disable iff (reset)
         (state_ff == RUN_ST) && (row_ff == lim_ff) && (col_ff == lim_ff) |=>
            (state_ff == IDLE_ST);
   endproperty
   a_run_ends: assert property (p_run_ends)
      else $error("sequencer did not return to idle after the final product");

   property p_row_continues;
      @(posedge clock) disable iff (reset)
         ctl_ff.valid && !ctl_ff.last_col |=>
            ctl_ff.valid && !ctl_ff.first && (ctl_ff.row == $past(ctl_ff.row));
   endproperty
   a_row_continues: assert property (p_row_continues)
      else $error("row accumulation interrupted before its final column");

endmodule

/* rtl/matrix_vector_multiply.sv */
// Top level of the dense matrix-vector multiplier on signed Q8.8 operands.
//
// Usage: a transaction is taken on the request ports at a rising edge where start is
// high and busy is low. Command write-matrix stores one entry at row and column,
// write-vector stores one vector entry at the column index; neither raises busy, so
// the block can take another transaction in the very next cycle. Command start runs
// the product over the active size n held in the size register (written through the
// csr_ port, n clamped to 1..16). Busy stays high while the n*n products run,
// one per cycle through a single shared multiply-accumulate unit fed by the matrix
// and vector memories. Row i appears on the rsp_ ports, marked by rsp_strobe for one
// cycle, after the memory read, product and accumulator registers; the last row
// carries rsp_last_element. The receiver cannot hold results off, and none is needed:
// each result leaves only after its row of n products. Reset clears the sequencer and
// sets the size to 16; the memories keep undefined contents until written.
`timescale 1ns / 1ps

module matrix_vector_multiply #(
   parameter int MAX_DIM = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_command,
   input  logic [mvm_pkg::INDEX_W-1:0]            req_row_index,
   input  logic [mvm_pkg::INDEX_W-1:0]            req_column_index,
   input  logic signed [mvm_pkg::OPERAND_W-1:0]   req_operand_value,
   output logic                                   rsp_strobe,
   output logic [mvm_pkg::INDEX_W-1:0]            rsp_result_index,
   output logic signed [mvm_pkg::RESULT_W-1:0]    rsp_result_value,
   output logic                                   rsp_last_element,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mvm_pkg::SIZE_W-1:0]             csr_data
);

   localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
   localparam int MAT_AW    = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
   localparam int VEC_AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   logic [mvm_pkg::SIZE_W-1:0]          size_ff;
   logic                                accept;
   logic                                mat_we;
   logic                                vec_we;
   logic [MAT_AW-1:0]                   mat_wr_addr;
   logic [MAT_AW-1:0]                   mat_rd_addr;
   logic [VEC_AW-1:0]                   vec_wr_addr;
   logic [VEC_AW-1:0]                   vec_rd_addr;
   logic [mvm_pkg::INDEX_W-1:0]         rd_row;
   logic [mvm_pkg::INDEX_W-1:0]         rd_col;
   logic [mvm_pkg::OPERAND_W-1:0]       mat_data;
   logic [mvm_pkg::OPERAND_W-1:0]       vec_data;
   mvm_pkg::mac_ctl_type                ctl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= mvm_pkg::SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         size_ff <= csr_data;
      end
   end

   assign accept = start && !busy;
   assign mat_we = accept && (req_command == mvm_pkg::CMD_WRITE_MATRIX)
                   && (int'(req_row_index) < MAX_DIM) && (int'(req_column_index) < MAX_DIM);
   assign vec_we = accept && (req_command == mvm_pkg::CMD_WRITE_VECTOR)
                   && (int'(req_column_index) < MAX_DIM);

   assign mat_wr_addr = MAT_AW'(int'(req_row_index) * MAX_DIM + int'(req_column_index));
   assign mat_rd_addr = MAT_AW'(int'(rd_row) * MAX_DIM + int'(rd_col));
   assign vec_wr_addr = VEC_AW'(req_column_index);
   assign vec_rd_addr = VEC_AW'(rd_col);

   mvm_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_command),
      .size    (size_ff),
      .busy    (busy),
      .rd_row  (rd_row),
      .rd_col  (rd_col),
      .ctl     (ctl)
   );

   mvm_ram #(
      .WIDTH (mvm_pkg::OPERAND_W),
      .DEPTH (MAT_DEPTH)
   ) u_matrix_ram (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (mat_wr_addr),
      .wr_data (req_operand_value),
      .rd_addr (mat_rd_addr),
      .rd_data (mat_data)
   );

   mvm_ram #(
      .WIDTH (mvm_pkg::OPERAND_W),
      .DEPTH (MAX_DIM)
   ) u_vector_ram (
      .clock   (clock),
      .wr_en   (vec_we),
      .wr_addr (vec_wr_addr),
      .wr_data (req_operand_value),
      .rd_addr (vec_rd_addr),
      .rd_data (vec_data)
   );

   mvm_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .matrix_data (mat_data),
      .vector_data (vec_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_index   (rsp_result_index),
      .rsp_value   (rsp_result_value),
      .rsp_last    (rsp_last_element)
   );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the matrix-vector multiplier: directed corners, then random traffic.
`timescale 1ns / 1ps

module tb_top;

   localparam int DIM = 16;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 6;
   localparam int DRAIN_CYCLES = 20;
   localparam int QUIET_LIMIT = 400;
   localparam int RANDOM_ITEMS = 80;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [mvm_pkg::INDEX_W-1:0]         index;
      logic signed [mvm_pkg::RESULT_W-1:0] value;
      logic                                last;
   } row_result_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 start = 1'b0;
   logic                                 busy;
   logic [1:0]                           req_command = mvm_pkg::CMD_WRITE_MATRIX;
   logic [mvm_pkg::INDEX_W-1:0]          req_row_index = '0;
   logic [mvm_pkg::INDEX_W-1:0]          req_column_index = '0;
   logic signed [mvm_pkg::OPERAND_W-1:0] req_operand_value = '0;
   logic                                 rsp_strobe;
   logic [mvm_pkg::INDEX_W-1:0]          rsp_result_index;
   logic signed [mvm_pkg::RESULT_W-1:0]  rsp_result_value;
   logic                                 rsp_last_element;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [mvm_pkg::SIZE_W-1:0]           csr_data = '0;

   logic signed [mvm_pkg::OPERAND_W-1:0] matrix_copy [DIM][DIM];
   logic signed [mvm_pkg::OPERAND_W-1:0] vector_copy [DIM];
   bit                                   matrix_loaded [DIM][DIM];
   bit                                   vector_loaded [DIM];
   logic [mvm_pkg::SIZE_W-1:0]           size_copy = mvm_pkg::SIZE_RESET;
   row_result_type                       rows_due [$];
   row_result_type                       head_row;

   int  mismatches = 0;
   int  items_sent = 0;
   int  multiplies = 0;
   int  rows_checked = 0;
   int  size_writes = 0;
   int  quiet_cycles = 0;
   bit  no_gaps = 1'b0;

   matrix_vector_multiply #(
      .MAX_DIM(DIM)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_row_index     (req_row_index),
      .req_column_index  (req_column_index),
      .req_operand_value (req_operand_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_result_index  (rsp_result_index),
      .rsp_result_value  (rsp_result_value),
      .rsp_last_element  (rsp_last_element),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int active_size(logic [mvm_pkg::SIZE_W-1:0] size);
      int n;
      n = int'(size);
      if (n < 1) n = 1;
      if (n > mvm_pkg::RESULT_REACH) n = mvm_pkg::RESULT_REACH;
      if (n > DIM) n = DIM;
      return n;
   endfunction

   function automatic void predict_rows(logic [1:0] command,
                                        logic [mvm_pkg::INDEX_W-1:0] row,
                                        logic [mvm_pkg::INDEX_W-1:0] col,
                                        logic signed [mvm_pkg::OPERAND_W-1:0] operand);
      int             n;
      longint         acc;
      row_result_type due;
      unique case (command)
         mvm_pkg::CMD_WRITE_MATRIX: begin
            matrix_copy[row][col] = operand;
            matrix_loaded[row][col] = 1'b1;
         end
         mvm_pkg::CMD_WRITE_VECTOR: begin
            vector_copy[col] = operand;
            vector_loaded[col] = 1'b1;
         end
         mvm_pkg::CMD_START: begin
            n = active_size(size_copy);
            for (int i = 0; i < n; i++) begin
               acc = 0;
               for (int j = 0; j < n; j++)
                  acc += longint'(matrix_copy[i][j]) * longint'(vector_copy[j]);
               due.index = mvm_pkg::INDEX_W'(i);
               due.value = mvm_pkg::RESULT_W'(acc);
               due.last = (i == n - 1);
               rows_due.push_back(due);
            end
            multiplies++;
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(input logic [1:0] command,
                            input logic [mvm_pkg::INDEX_W-1:0] row,
                            input logic [mvm_pkg::INDEX_W-1:0] col,
                            input logic signed [mvm_pkg::OPERAND_W-1:0] operand);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= command;
      req_row_index <= row;
      req_column_index <= col;
      req_operand_value <= operand;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_rows(command, row, col, operand);
      if (command != CMD_UNUSED) items_sent++;
   endtask

   task automatic settle_idle();
      start <= 1'b0;
      while (rows_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic [mvm_pkg::SIZE_W-1:0] size);
      settle_idle();
      csr_valid <= 1'b1;
      csr_data <= size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      size_copy = size;
      size_writes++;
   endtask

   // Entries inside the active size that were never written are loaded first.
   task automatic run_multiply();
      int n;
      n = active_size(size_copy);
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++)
            if (!matrix_loaded[i][j])
               send_item(mvm_pkg::CMD_WRITE_MATRIX, mvm_pkg::INDEX_W'(i),
                         mvm_pkg::INDEX_W'(j), mvm_pkg::OPERAND_W'($urandom));
      for (int j = 0; j < n; j++)
         if (!vector_loaded[j])
            send_item(mvm_pkg::CMD_WRITE_VECTOR, mvm_pkg::INDEX_W'($urandom),
                      mvm_pkg::INDEX_W'(j), mvm_pkg::OPERAND_W'($urandom));
      send_item(mvm_pkg::CMD_START, mvm_pkg::INDEX_W'($urandom),
                mvm_pkg::INDEX_W'($urandom), mvm_pkg::OPERAND_W'($urandom));
   endtask

   task automatic test_extreme_sums();
      for (int j = 0; j < DIM; j++) begin
         send_item(mvm_pkg::CMD_WRITE_MATRIX, 4'd0, mvm_pkg::INDEX_W'(j), 16'sh8000);
         send_item(mvm_pkg::CMD_WRITE_MATRIX, 4'd1, mvm_pkg::INDEX_W'(j), 16'sh7FFF);
         send_item(mvm_pkg::CMD_WRITE_VECTOR, mvm_pkg::INDEX_W'($urandom),
                   mvm_pkg::INDEX_W'(j), 16'sh8000);
      end
      send_item(CMD_UNUSED, 4'hF, 4'hF, 16'shFFFF);
      run_multiply();
   endtask

   task automatic test_size_corners();
      write_size(5'd1);
      send_item(mvm_pkg::CMD_WRITE_MATRIX, 4'd0, 4'd0, 16'sh0000);
      run_multiply();
      send_item(mvm_pkg::CMD_WRITE_MATRIX, 4'd0, 4'd0, 16'shFFFF);
      send_item(mvm_pkg::CMD_WRITE_VECTOR, 4'd0, 4'd0, 16'sh7FFF);
      no_gaps = 1'b1;
      run_multiply();
      run_multiply();
      no_gaps = 1'b0;
      write_size(5'd0);
      run_multiply();
      write_size(5'd31);
      send_item(CMD_UNUSED, 4'd0, 4'd0, 16'sh0000);
      run_multiply();
      write_size(5'd17);
      run_multiply();
      write_size(5'd2);
      run_multiply();
   endtask

   task automatic test_random_traffic();
      int target;
      int pick;
      int n;
      int burst;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) write_size(mvm_pkg::SIZE_W'($urandom_range(1, 5)));
         else if (pick < 8) write_size(mvm_pkg::SIZE_W'($urandom_range(6, 16)));
         else write_size(mvm_pkg::SIZE_W'($urandom_range(0, 31)));
         n = active_size(size_copy);
         no_gaps = ($urandom_range(0, 3) == 0);
         burst = $urandom_range(10, 40);
         repeat (burst) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
               send_item(mvm_pkg::CMD_WRITE_MATRIX,
                         mvm_pkg::INDEX_W'(pick < 35 ? $urandom_range(0, n - 1) : $urandom),
                         mvm_pkg::INDEX_W'(pick < 35 ? $urandom_range(0, n - 1) : $urandom),
                         mvm_pkg::OPERAND_W'($urandom));
            else if (pick < 70)
               send_item(mvm_pkg::CMD_WRITE_VECTOR, mvm_pkg::INDEX_W'($urandom),
                         mvm_pkg::INDEX_W'(pick < 62 ? $urandom_range(0, n - 1) : $urandom),
                         mvm_pkg::OPERAND_W'($urandom));
            else if (pick < 92)
               run_multiply();
            else
               send_item(CMD_UNUSED, mvm_pkg::INDEX_W'($urandom),
                         mvm_pkg::INDEX_W'($urandom), mvm_pkg::OPERAND_W'($urandom));
         end
         no_gaps = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (rows_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("Unexpected result: index %0d value %0d last %0b",
                        rsp_result_index, rsp_result_value, rsp_last_element);
         end else begin
            head_row = rows_due.pop_front();
            rows_checked++;
            if (rsp_result_index !== head_row.index || rsp_result_value !== head_row.value ||
                rsp_last_element !== head_row.last) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("Mismatch: expected index %0d value %0d last %0b, got %0d %0d %0b",
                           head_row.index, head_row.value, head_row.last,
                           rsp_result_index, rsp_result_value, rsp_last_element);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extreme_sums();
      test_size_corners();
      test_random_traffic();
      settle_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d transactions with %0d multiplies and %0d size writes.",
               items_sent, multiplies, size_writes);
      $display("Checked %0d result rows, %0d mismatches.", rows_checked, mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/mvm_pkg.sv
rtl/mvm_ram.sv
rtl/mvm_mac.sv
rtl/mvm_ctrl.sv
rtl/matrix_vector_multiply.sv
sim/tb_top.sv
